/* hw/rtl/token_expression_evaluator_unit_defines.svh */
// Assertion macros shared by the token expression evaluator RTL.
`ifndef TOKEN_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define TOKEN_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define TEV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define TEV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define TEV_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define TEV_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/tev_pkg.sv */
// Package: token codes, error codes and token classes of the expression evaluator.
`timescale 1ns / 1ps
`default_nettype none

package tev_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int OUT_WIDTH           = 32;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [2:0] OPC_NUMBER = 3'd0;
   localparam logic [2:0] OPC_NAME   = 3'd1;
   localparam logic [2:0] OPC_PLUS   = 3'd2;
   localparam logic [2:0] OPC_MINUS  = 3'd3;
   localparam logic [2:0] OPC_MUL    = 3'd4;
   localparam logic [2:0] OPC_DIV    = 3'd5;
   localparam logic [2:0] OPC_MOD    = 3'd6;

   localparam logic [2:0] ERR_OK         = 3'd0;
   localparam logic [2:0] ERR_SYNTAX     = 3'd1;
   localparam logic [2:0] ERR_UNDEFINED  = 3'd2;
   localparam logic [2:0] ERR_UNRESOLVED = 3'd3;
   localparam logic [2:0] ERR_NOT_ABS    = 3'd4;
   localparam logic [2:0] ERR_DIV_ZERO   = 3'd5;

   localparam logic [1:0] SYM_UNDEFINED = 2'd0;
   localparam logic [1:0] SYM_ABSOLUTE  = 2'd1;

   localparam logic [1:0] MUL_NONE = 2'd0;
   localparam logic [1:0] MUL_MUL  = 2'd1;
   localparam logic [1:0] MUL_DIV  = 2'd2;
   localparam logic [1:0] MUL_MOD  = 2'd3;

   localparam logic ADD_PLUS  = 1'b0;
   localparam logic ADD_MINUS = 1'b1;

   typedef enum logic [1:0] {
      TOK_OPERAND,
      TOK_ADDOP,
      TOK_MULOP,
      TOK_OTHER
   } tok_class_type;

   typedef struct packed {
      tok_class_type cls;
      logic [1:0]    sub;
      logic [2:0]    err;
   } tok_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/token_expression_evaluator_unit.sv */
// Top level of the token expression evaluator: front classifier, queue and back executor.
//
// Evaluates an infix expression of numbers and looked-up symbols, one token per item,
// with + and - below *, / and %, all wrapping at VALUE_WIDTH bits. The front takes an
// item in any cycle while its two-entry queue has room, so it keeps accepting while a
// result waits at the output. The back takes one queued token per cycle while it is idle and
// no result is held back by rsp_stall; an operand that follows *, / or % occupies the shared
// bit-serial multiply/divide unit, one bit per cycle over all VALUE_WIDTH bits, and no
// token is taken meanwhile. A result appears in the output register the cycle after the
// token that ends the expression, or the error token, leaves the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "token_expression_evaluator_unit_defines.svh"

module token_expression_evaluator_unit
   import tev_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_opcode,
   input  wire logic signed [31:0] req_operand_value,
   input  wire logic               req_symbol_found,
   input  wire logic [1:0]         req_symbol_kind,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_expression_value,
   output logic [2:0]              rsp_error_code,
   output logic                    rsp_token_consumed
);

   logic                   tok_valid;
   tok_ctl_type            tok_ctl;
   logic [VALUE_WIDTH-1:0] tok_value;
   logic                   tok_ready;

   tev_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_operand_value (req_operand_value),
      .req_symbol_found  (req_symbol_found),
      .req_symbol_kind   (req_symbol_kind),
      .tok_valid         (tok_valid),
      .tok_ctl           (tok_ctl),
      .tok_value         (tok_value),
      .tok_ready         (tok_ready)
   );

   tev_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .tok_valid            (tok_valid),
      .tok_ctl              (tok_ctl),
      .tok_value            (tok_value),
      .tok_ready            (tok_ready),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_expression_value (rsp_expression_value),
      .rsp_error_code       (rsp_error_code),
      .rsp_token_consumed   (rsp_token_consumed)
   );

   `TEV_ASSERT_IMPLIES(a_pop_needs_item, clock, reset, tok_ready, tok_valid)
   `TEV_ASSERT_IMPLIES(a_no_pop_when_blocked, clock, reset, rsp_valid && rsp_stall, !tok_ready)
   `TEV_ASSERT_IMPLIES(a_error_value_zero, clock, reset, rsp_valid && (rsp_error_code != ERR_OK), rsp_expression_value == '0)
   `TEV_ASSERT_IMPLIES(a_consumed_only_div_zero, clock, reset, rsp_valid, rsp_token_consumed == (rsp_error_code == ERR_DIV_ZERO))

endmodule

`default_nettype wire

/* hw/rtl/tev_queue.sv */
// Small FIFO of classified items between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module tev_queue
   import tev_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  wire tok_ctl_type            push_ctl,
   input  wire logic [VALUE_WIDTH-1:0] push_value,
   output logic                        full,
   output logic                        pop_valid,
   output tok_ctl_type                 pop_ctl,
   output logic [VALUE_WIDTH-1:0]      pop_value,
   input  wire logic                   pop_ready
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   tok_ctl_type            ctl_mem_ff [QUEUE_DEPTH];
   logic [VALUE_WIDTH-1:0] val_mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_ctl   = ctl_mem_ff[rd_ptr_ff];
   assign pop_value = val_mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ctl_mem_ff[wr_ptr_ff] <= push_ctl;
         val_mem_ff[wr_ptr_ff] <= push_value;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/tev_front.sv */
// Front part: accepts items, classifies each token and queues it for the back part.
`timescale 1ns / 1ps
`default_nettype none

module tev_front
   import tev_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [2:0]             req_opcode,
   input  wire logic signed [31:0]     req_operand_value,
   input  wire logic                   req_symbol_found,
   input  wire logic [1:0]             req_symbol_kind,
   output logic                        tok_valid,
   output tok_ctl_type                 tok_ctl,
   output logic [VALUE_WIDTH-1:0]      tok_value,
   input  wire logic                   tok_ready
);

   tok_ctl_type            cls_ctl;
   logic [VALUE_WIDTH-1:0] cls_value;
   logic                   q_full;

   generate
      if (VALUE_WIDTH > 32) begin : g_wide
         assign cls_value = {{(VALUE_WIDTH - 32){req_operand_value[31]}}, req_operand_value};
      end else if (VALUE_WIDTH == 32) begin : g_same
         assign cls_value = req_operand_value;
      end else begin : g_narrow
         assign cls_value = req_operand_value[VALUE_WIDTH-1:0];
      end
   endgenerate

   always_comb begin
      cls_ctl.cls = TOK_OTHER;
      cls_ctl.sub = MUL_NONE;
      cls_ctl.err = ERR_SYNTAX;
      case (req_opcode)
         OPC_NUMBER: begin
            cls_ctl.cls = TOK_OPERAND;
            cls_ctl.err = ERR_OK;
         end
         OPC_NAME: begin
            cls_ctl.cls = TOK_OPERAND;
            if (!req_symbol_found) begin
               cls_ctl.err = ERR_UNDEFINED;
            end else if (req_symbol_kind == SYM_UNDEFINED) begin
               cls_ctl.err = ERR_UNRESOLVED;
            end else if (req_symbol_kind != SYM_ABSOLUTE) begin
               cls_ctl.err = ERR_NOT_ABS;
            end else begin
               cls_ctl.err = ERR_OK;
            end
         end
         OPC_PLUS: begin
            cls_ctl.cls = TOK_ADDOP;
            cls_ctl.sub = {1'b0, ADD_PLUS};
         end
         OPC_MINUS: begin
            cls_ctl.cls = TOK_ADDOP;
            cls_ctl.sub = {1'b0, ADD_MINUS};
         end
         OPC_MUL: begin
            cls_ctl.cls = TOK_MULOP;
            cls_ctl.sub = MUL_MUL;
         end
         OPC_DIV: begin
            cls_ctl.cls = TOK_MULOP;
            cls_ctl.sub = MUL_DIV;
         end
         OPC_MOD: begin
            cls_ctl.cls = TOK_MULOP;
            cls_ctl.sub = MUL_MOD;
         end
         default: begin
            cls_ctl.cls = TOK_OTHER;
         end
      endcase
   end

   assign req_stall = q_full;

   tev_queue #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ctl   (cls_ctl),
      .push_value (cls_value),
      .full       (q_full),
      .pop_valid  (tok_valid),
      .pop_ctl    (tok_ctl),
      .pop_value  (tok_value),
      .pop_ready  (tok_ready)
   );

endmodule

`default_nettype wire

/* hw/rtl/tev_back.sv */
// Back part: parser state, shared bit-serial multiply/divide unit and result register.
`timescale 1ns / 1ps
`default_nettype none

module tev_back
   import tev_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   tok_valid,
   input  wire tok_ctl_type            tok_ctl,
   input  wire logic [VALUE_WIDTH-1:0] tok_value,
   output logic                        tok_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [31:0]          rsp_expression_value,
   output logic [2:0]                  rsp_error_code,
   output logic                        rsp_token_consumed
);

   localparam int W  = VALUE_WIDTH;
   localparam int CW = $clog2(W);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_DIV  = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic           expect_ff, expect_in;
   logic [W-1:0]   sum_ff, sum_in;
   logic [W-1:0]   term_ff, term_in;
   logic           add_op_ff, add_op_in;
   logic [1:0]     mul_op_ff, mul_op_in;
   logic [W-1:0]   acc_ff, acc_in;
   logic [W-1:0]   shf_ff, shf_in;
   logic [W-1:0]   opb_ff, opb_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           qneg_ff, qneg_in;
   logic           rneg_ff, rneg_in;
   logic           mode_ff, mode_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]   rsp_value_ff, rsp_value_in;
   logic [2:0]     rsp_err_ff, rsp_err_in;
   logic           rsp_cons_ff, rsp_cons_in;

   logic           pop;
   logic           last;
   logic [W-1:0]   sum_new;
   logic [W-1:0]   mul_sum;
   logic [W:0]     div_shift;
   logic           div_ge;
   logic [W-1:0]   div_rem;
   logic [W-1:0]   div_q;
   logic [W-1:0]   term_abs;
   logic [W-1:0]   val_abs;

   assign pop       = tok_valid && (!rsp_valid_ff || !rsp_stall);
   assign last      = (cnt_ff == CW'(W - 1));
   assign sum_new   = (add_op_ff == ADD_MINUS) ? sum_ff - term_ff : sum_ff + term_ff;
   assign mul_sum   = acc_ff + (shf_ff[0] ? opb_ff : '0);
   assign div_shift = {acc_ff, shf_ff[W-1]};
   assign div_ge    = (div_shift >= {1'b0, opb_ff});
   assign div_rem   = div_ge ? W'(div_shift - {1'b0, opb_ff}) : div_shift[W-1:0];
   assign div_q     = {shf_ff[W-2:0], div_ge};
   assign term_abs  = term_ff[W-1] ? '0 - term_ff : term_ff;
   assign val_abs   = tok_value[W-1] ? '0 - tok_value : tok_value;

   always_comb begin
      state_in     = state_ff;
      expect_in    = expect_ff;
      sum_in       = sum_ff;
      term_in      = term_ff;
      add_op_in    = add_op_ff;
      mul_op_in    = mul_op_ff;
      acc_in       = acc_ff;
      shf_in       = shf_ff;
      opb_in       = opb_ff;
      cnt_in       = cnt_ff;
      qneg_in      = qneg_ff;
      rneg_in      = rneg_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_cons_in  = rsp_cons_ff;
      tok_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            tok_ready = pop;
            if (pop) begin
               if (!expect_ff) begin
                  if (tok_ctl.err != ERR_OK) begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_err_in   = tok_ctl.err;
                     rsp_cons_in  = 1'b0;
                     expect_in    = 1'b0;
                     sum_in       = '0;
                     term_in      = '0;
                     add_op_in    = ADD_PLUS;
                     mul_op_in    = MUL_NONE;
                  end else begin
                     case (mul_op_ff)
                        MUL_NONE: begin
                           term_in   = tok_value;
                           expect_in = 1'b1;
                        end
                        MUL_MUL: begin
                           acc_in   = '0;
                           opb_in   = term_ff;
                           shf_in   = tok_value;
                           cnt_in   = '0;
                           state_in = ST_MUL;
                        end
                        default: begin
                           if (tok_value == '0) begin
                              rsp_valid_in = 1'b1;
                              rsp_value_in = '0;
                              rsp_err_in   = ERR_DIV_ZERO;
                              rsp_cons_in  = 1'b1;
                              expect_in    = 1'b0;
                              sum_in       = '0;
                              term_in      = '0;
                              add_op_in    = ADD_PLUS;
                              mul_op_in    = MUL_NONE;
                           end else begin
                              acc_in   = '0;
                              shf_in   = term_abs;
                              opb_in   = val_abs;
                              qneg_in  = term_ff[W-1] ^ tok_value[W-1];
                              rneg_in  = term_ff[W-1];
                              mode_in  = (mul_op_ff == MUL_MOD);
                              cnt_in   = '0;
                              state_in = ST_DIV;
                           end
                        end
                     endcase
                  end
               end else if (tok_ctl.cls == TOK_MULOP) begin
                  mul_op_in = tok_ctl.sub;
                  expect_in = 1'b0;
               end else if (tok_ctl.cls == TOK_ADDOP) begin
                  sum_in    = sum_new;
                  term_in   = '0;
                  add_op_in = tok_ctl.sub[0];
                  mul_op_in = MUL_NONE;
                  expect_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = sum_new;
                  rsp_err_in   = ERR_OK;
                  rsp_cons_in  = 1'b0;
                  expect_in    = 1'b0;
                  sum_in       = '0;
                  term_in      = '0;
                  add_op_in    = ADD_PLUS;
                  mul_op_in    = MUL_NONE;
               end
            end
         end
         ST_MUL: begin
            acc_in = mul_sum;
            opb_in = opb_ff << 1;
            shf_in = shf_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               term_in   = mul_sum;
               expect_in = 1'b1;
               mul_op_in = MUL_NONE;
               state_in  = ST_IDLE;
            end
         end
         ST_DIV: begin
            acc_in = div_rem;
            shf_in = div_q;
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               if (mode_ff) begin
                  term_in = rneg_ff ? '0 - div_rem : div_rem;
               end else begin
                  term_in = qneg_ff ? '0 - div_q : div_q;
               end
               expect_in = 1'b1;
               mul_op_in = MUL_NONE;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         expect_ff    <= 1'b0;
         sum_ff       <= '0;
         term_ff      <= '0;
         add_op_ff    <= ADD_PLUS;
         mul_op_ff    <= MUL_NONE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expect_ff    <= expect_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         add_op_ff    <= add_op_in;
         mul_op_ff    <= mul_op_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      shf_ff       <= shf_in;
      opb_ff       <= opb_in;
      qneg_ff      <= qneg_in;
      rneg_ff      <= rneg_in;
      mode_ff      <= mode_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_cons_ff  <= rsp_cons_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_error_code     = rsp_err_ff;
   assign rsp_token_consumed = rsp_cons_ff;

   generate
      if (W > OUT_WIDTH) begin : g_wide
         assign rsp_expression_value = rsp_value_ff[OUT_WIDTH-1:0];
      end else if (W == OUT_WIDTH) begin : g_same
         assign rsp_expression_value = rsp_value_ff;
      end else begin : g_narrow
         assign rsp_expression_value = {{(OUT_WIDTH - W){rsp_value_ff[W-1]}}, rsp_value_ff};
      end
   endgenerate

endmodule

`default_nettype wire
